### hdl/qsel_pkg.sv
// shared constants for the k-th smallest selector
`timescale 1ns / 1ps

package qsel_pkg;

	// rank register
	localparam int unsigned RANK_W = 11;
	localparam logic [RANK_W-1:0] RANK_RESET = 11'd1;

	// apb port geometry
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// register word indexes (paddr above the byte lane bits)
	localparam logic [PADDR_W-3:0] REG_RANK = 1'b0;

endpackage : qsel_pkg

### hdl/qsel_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module qsel_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : qsel_ram

### hdl/qsel_cfg.sv
// apb register block holding the wanted rank
`timescale 1ns / 1ps

module qsel_cfg
	import qsel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [RANK_W-1:0]  rank
);

	logic [RANK_W-1:0] rank_q;
	logic              wr_en;
	logic              hit_rank;

	// address decode
	assign hit_rank = (paddr[PADDR_W-1:2] == REG_RANK);
	assign wr_en    = psel && penable && pwrite && hit_rank;

	// rank register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_RESET;
		end else if (wr_en) begin
			rank_q <= pwdata[RANK_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (hit_rank) begin
			prdata = PDATA_W'(rank_q);
		end
	end

	assign pready = 1'b1;
	assign rank   = rank_q;

endmodule : qsel_cfg

### hdl/qsel_seq.sv
// load and quickselect sequencer driving the element store
`timescale 1ns / 1ps

module qsel_seq
	import qsel_pkg::*;
#(
	parameter int unsigned DEPTH      = 1024,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DATA_WIDTH-1:0] element_value,
	input  logic                         is_last,
	input  logic [RANK_W-1:0]            rank,
	output logic                         busy,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] selected_value,
	output logic                         error,
	output logic                         ram_we,
	output logic [$clog2(DEPTH)-1:0]     ram_waddr,
	output logic [DATA_WIDTH-1:0]        ram_wdata,
	output logic                         ram_re,
	output logic [$clog2(DEPTH)-1:0]     ram_raddr,
	input  logic [DATA_WIDTH-1:0]        ram_rdata
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned RW = (CW > RANK_W) ? CW : RANK_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PIV_RD,
		S_PIV_CAP,
		S_LD_L,
		S_CAP_L,
		S_LD_R,
		S_CAP_R,
		S_STEP,
		S_SWAP1,
		S_SWAP2,
		S_FIN_RD,
		S_FIN_W1,
		S_FIN_W2
	} state_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_C
	} phase_t;

	state_t                  state_q;
	phase_t                  phase_q;
	logic                    ld_both_q;
	logic [CW-1:0]           count_q;
	logic                    ovf_q;
	logic [CW-1:0]           ws_q;
	logic [CW-1:0]           we_q;
	logic [CW-1:0]           left_q;
	logic [CW-1:0]           right_q;
	logic [CW-1:0]           target_q;
	logic signed [DATA_WIDTH-1:0] pivot_q;
	logic signed [DATA_WIDTH-1:0] lv_q;
	logic signed [DATA_WIDTH-1:0] rv_q;
	logic                    done_q;
	logic                    error_q;
	logic signed [DATA_WIDTH-1:0] sel_q;

	logic                    full;
	logic [CW-1:0]           count_nx;
	logic                    ovf_nx;
	logic [RW-1:0]           rank_ext;
	logic                    req_err;
	logic [CW-1:0]           left_inc;
	logic [CW-1:0]           right_dec;
	logic [CW-1:0]           ws_inc;
	logic                    in_window;
	logic                    l_above;
	logic                    r_below;
	logic                    l_not_above;
	logic                    r_not_below;
	logic signed [DATA_WIDTH-1:0] rdata_s;

	// request bookkeeping for the load phase
	assign full     = (count_q >= FULL_CNT);
	assign count_nx = full ? count_q : count_q + 1'b1;
	assign ovf_nx   = ovf_q | full;
	assign rank_ext = RW'(rank);
	assign req_err  = ovf_nx || (rank == '0) || (rank_ext > RW'(count_nx));

	// shared index step and compare unit
	assign left_inc    = left_q + 1'b1;
	assign right_dec   = right_q - 1'b1;
	assign ws_inc      = ws_q + 1'b1;
	assign in_window   = (left_q <= right_q);
	assign l_above     = (lv_q > pivot_q);
	assign r_below     = (rv_q < pivot_q);
	assign l_not_above = !l_above;
	assign r_not_below = !r_below;
	assign rdata_s     = ram_rdata;

	// store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = element_value;
		ram_re    = 1'b0;
		ram_raddr = left_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_we = start && !full;
			end
			S_PIV_RD: begin
				ram_re    = 1'b1;
				ram_raddr = ws_q[AW-1:0];
			end
			S_LD_L: begin
				ram_re = 1'b1;
			end
			S_LD_R, S_FIN_RD: begin
				ram_re    = 1'b1;
				ram_raddr = right_q[AW-1:0];
			end
			S_SWAP1: begin
				ram_we    = 1'b1;
				ram_waddr = left_q[AW-1:0];
				ram_wdata = rv_q;
			end
			S_SWAP2: begin
				ram_we    = 1'b1;
				ram_waddr = right_q[AW-1:0];
				ram_wdata = lv_q;
			end
			S_FIN_W1: begin
				ram_we    = 1'b1;
				ram_waddr = ws_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			S_FIN_W2: begin
				ram_we    = 1'b1;
				ram_waddr = right_q[AW-1:0];
				ram_wdata = pivot_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_A;
			ld_both_q <= 1'b0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			done_q    <= 1'b0;
			error_q   <= 1'b0;
			ws_q      <= '0;
			we_q      <= '0;
			left_q    <= '0;
			right_q   <= '0;
			target_q  <= '0;
			pivot_q   <= '0;
			lv_q      <= '0;
			rv_q      <= '0;
			sel_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (is_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							if (req_err) begin
								done_q  <= 1'b1;
								error_q <= 1'b1;
								sel_q   <= '0;
							end else begin
								ws_q     <= '0;
								we_q     <= count_nx - 1'b1;
								target_q <= CW'(rank_ext - 1'b1);
								state_q  <= S_PIV_RD;
							end
						end else begin
							count_q <= count_nx;
							ovf_q   <= ovf_nx;
						end
					end
				end
				S_PIV_RD: begin
					state_q <= S_PIV_CAP;
				end
				S_PIV_CAP: begin
					pivot_q   <= rdata_s;
					left_q    <= ws_inc;
					right_q   <= we_q;
					phase_q   <= PH_A;
					ld_both_q <= 1'b1;
					state_q   <= (ws_inc <= we_q) ? S_LD_L : S_STEP;
				end
				S_LD_L: begin
					state_q <= S_CAP_L;
				end
				S_CAP_L: begin
					lv_q    <= rdata_s;
					state_q <= ld_both_q ? S_LD_R : S_STEP;
				end
				S_LD_R: begin
					state_q <= S_CAP_R;
				end
				S_CAP_R: begin
					rv_q    <= rdata_s;
					state_q <= S_STEP;
				end
				S_STEP: begin
					case (phase_q)
						PH_A: begin
							if (!in_window) begin
								state_q <= S_FIN_RD;
							end else if (l_above && r_below) begin
								state_q <= S_SWAP1;
							end else begin
								phase_q <= PH_B;
							end
						end
						PH_B: begin
							phase_q <= PH_C;
							if (in_window && l_not_above) begin
								left_q    <= left_inc;
								ld_both_q <= 1'b0;
								if (left_inc <= right_q) begin
									state_q <= S_LD_L;
								end
							end
						end
						default: begin
							phase_q <= PH_A;
							if (in_window && r_not_below) begin
								right_q <= right_dec;
								if (left_q <= right_dec) begin
									state_q <= S_LD_R;
								end
							end
						end
					endcase
				end
				S_SWAP1: begin
					state_q <= S_SWAP2;
				end
				S_SWAP2: begin
					left_q    <= left_inc;
					right_q   <= right_dec;
					phase_q   <= PH_B;
					ld_both_q <= 1'b1;
					state_q   <= (left_inc <= right_dec) ? S_LD_L : S_STEP;
				end
				S_FIN_RD: begin
					state_q <= S_FIN_W1;
				end
				S_FIN_W1: begin
					state_q <= S_FIN_W2;
				end
				S_FIN_W2: begin
					if (right_q == target_q) begin
						done_q  <= 1'b1;
						error_q <= 1'b0;
						sel_q   <= pivot_q;
						state_q <= S_IDLE;
					end else begin
						if (right_q < target_q) begin
							ws_q <= right_q + 1'b1;
						end else begin
							we_q <= right_dec;
						end
						state_q <= S_PIV_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign error          = error_q;
	assign selected_value = sel_q;

endmodule : qsel_seq

### hdl/kth_smallest_quickselect.sv
// k-th smallest selector: loads a signed array, then selects by quickselect
// loading takes one request per cycle while not busy; a last request in error answers next cycle
// otherwise each partition of a window scans its elements through the element store,
// which has one write and one read port, reading or swapping one element at a time
// the selection time is data dependent; done strobes one cycle
// reset: async clear of control state, rank returns to 1, store contents undefined
`timescale 1ns / 1ps

module kth_smallest_quickselect
	import qsel_pkg::*;
#(
	parameter int unsigned DEPTH      = 1024,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] element_value,
	input  logic                         is_last,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] selected_value,
	output logic                         error,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [PADDR_W-1:0]           paddr,
	input  logic [PDATA_W-1:0]           pwdata,
	output logic [PDATA_W-1:0]           prdata,
	output logic                         pready
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [RANK_W-1:0]     rank;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// configuration registers
	qsel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rank    (rank)
	);

	// element store
	qsel_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// load and select sequencer
	qsel_seq #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.element_value  (element_value),
		.is_last        (is_last),
		.rank           (rank),
		.busy           (busy),
		.done           (done),
		.selected_value (selected_value),
		.error          (error),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata)
	);

endmodule : kth_smallest_quickselect
